### rtl/core/dmlg_pkg.sv
`default_nettype none
package dmlg_pkg;

    localparam int unsigned DataW     = 40;
    localparam int unsigned CfgIndexW = 3;
    localparam int unsigned CfgDataW  = 24;
    localparam int unsigned PosW      = 24;
    localparam int unsigned EdgeW     = 4;
    localparam int unsigned CodeW     = 12;
    localparam int unsigned DutyW     = 10;
    localparam int unsigned TickW     = 16;

    localparam logic [CfgIndexW-1:0] REG_DRIVE_DUTY    = 3'd0;
    localparam logic [CfgIndexW-1:0] REG_CURRENT_ZERO  = 3'd1;
    localparam logic [CfgIndexW-1:0] REG_CURRENT_LIMIT = 3'd2;
    localparam logic [CfgIndexW-1:0] REG_STALL_TIMEOUT = 3'd3;
    localparam logic [CfgIndexW-1:0] REG_UPPER_LIMIT   = 3'd4;
    localparam logic [CfgIndexW-1:0] REG_LOWER_LIMIT   = 3'd5;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    localparam logic [2:0] CAUSE_NONE        = 3'd0;
    localparam logic [2:0] CAUSE_UPPER_LIMIT = 3'd1;
    localparam logic [2:0] CAUSE_LOWER_LIMIT = 3'd2;
    localparam logic [2:0] CAUSE_OVERCURRENT = 3'd3;
    localparam logic [2:0] CAUSE_STALL       = 3'd4;

    typedef struct packed {
        logic [DutyW-1:0]        drive_duty;
        logic [CodeW-1:0]        current_zero_code;
        logic [CodeW-1:0]        current_limit_code;
        logic [TickW-1:0]        stall_timeout_ticks;
        logic signed [PosW-1:0]  upper_limit_pulses;
        logic signed [PosW-1:0]  lower_limit_pulses;
    } cfg_t;

    typedef struct packed {
        logic [CodeW-1:0] current_two_code;
        logic [CodeW-1:0] current_one_code;
        logic [EdgeW-1:0] edges_motor_two;
        logic [EdgeW-1:0] edges_motor_one;
        logic             press_down;
        logic             press_up;
    } tick_t;

    typedef struct packed {
        logic [2:0]             stop_cause;
        logic signed [PosW-1:0] height_pulses;
        logic [DutyW-1:0]       duty_out;
        logic [1:0]             drive_direction;
    } result_t;

endpackage
`default_nettype wire

### rtl/core/dmlg_cfg_regs.sv
`default_nettype none
module dmlg_cfg_regs
    import dmlg_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CfgIndexW-1:0] cfg_index,
    input  wire logic [CfgDataW-1:0]  cfg_wdata,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_DRIVE_DUTY:    cfg_next.drive_duty          = cfg_wdata[DutyW-1:0];
                REG_CURRENT_ZERO:  cfg_next.current_zero_code   = cfg_wdata[CodeW-1:0];
                REG_CURRENT_LIMIT: cfg_next.current_limit_code  = cfg_wdata[CodeW-1:0];
                REG_STALL_TIMEOUT: cfg_next.stall_timeout_ticks = cfg_wdata[TickW-1:0];
                REG_UPPER_LIMIT:   cfg_next.upper_limit_pulses  = cfg_wdata[PosW-1:0];
                REG_LOWER_LIMIT:   cfg_next.lower_limit_pulses  = cfg_wdata[PosW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.drive_duty          <= 10'd1023;
            cfg_reg.current_zero_code   <= 12'd3102;
            cfg_reg.current_limit_code  <= 12'd819;
            cfg_reg.stall_timeout_ticks <= 16'd20;
            cfg_reg.upper_limit_pulses  <= 24'sh7FFFFF;
            cfg_reg.lower_limit_pulses  <= 24'sh000000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

### rtl/core/dmlg_step.sv
`default_nettype none
module dmlg_step
    import dmlg_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic step_en,
    input  tick_t     tick,
    input  cfg_t      cfg,
    output result_t   result
);

    logic signed [PosW-1:0] pos_one_reg, pos_one_next;
    logic signed [PosW-1:0] pos_two_reg, pos_two_next;
    logic [TickW-1:0]       idle_reg, idle_next;
    logic [1:0]             mode_reg, mode_next;
    logic                   fault_reg, fault_next;
    logic [2:0]             lcause_reg, lcause_next;

    logic [1:0]             req;
    logic                   fault_held;
    logic [2:0]             lcause_held;
    logic signed [EdgeW:0]  d_one, d_two;
    logic signed [PosW:0]   sum_one, sum_two, pos_sum, pos_adj;
    logic signed [PosW-1:0] h_avg, h_hi, h_fin;
    logic                   cont, any_edge, over_one, over_two, stall;
    logic [TickW-1:0]       idle_cnt;
    logic [CodeW:0]         diff_one, diff_two, abs_one, abs_two;
    logic [1:0]             dir;
    logic [2:0]             cause;

    function automatic logic signed [PosW-1:0] sat_pos(input logic signed [PosW:0] s);
        logic signed [PosW-1:0] r;
        if (s[PosW] != s[PosW-1]) begin
            r = s[PosW] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
        end else begin
            r = s[PosW-1:0];
        end
        return r;
    endfunction

    always_comb begin
        req         = tick.press_up ? DIR_UP : (tick.press_down ? DIR_DOWN : DIR_STOP);
        fault_held  = fault_reg & (tick.press_up | tick.press_down);
        lcause_held = fault_held ? lcause_reg : CAUSE_NONE;

        d_one = $signed({1'b0, tick.edges_motor_one});
        d_two = $signed({1'b0, tick.edges_motor_two});
        if (mode_reg == DIR_DOWN) begin
            d_one = -d_one;
            d_two = -d_two;
        end
        if (mode_reg == DIR_STOP) begin
            d_one = '0;
            d_two = '0;
        end
        sum_one      = {pos_one_reg[PosW-1], pos_one_reg} + {{(PosW-EdgeW){d_one[EdgeW]}}, d_one};
        sum_two      = {pos_two_reg[PosW-1], pos_two_reg} + {{(PosW-EdgeW){d_two[EdgeW]}}, d_two};
        pos_one_next = sat_pos(sum_one);
        pos_two_next = sat_pos(sum_two);

        pos_sum = {pos_one_next[PosW-1], pos_one_next} + {pos_two_next[PosW-1], pos_two_next};
        pos_adj = pos_sum + {{PosW{1'b0}}, pos_sum[PosW]};
        h_avg   = pos_adj[PosW:1];
        h_hi    = (h_avg > cfg.upper_limit_pulses) ? cfg.upper_limit_pulses : h_avg;
        h_fin   = (h_hi < cfg.lower_limit_pulses) ? cfg.lower_limit_pulses : h_hi;

        cont     = (mode_reg != DIR_STOP) && (req == mode_reg);
        any_edge = (tick.edges_motor_one != '0) || (tick.edges_motor_two != '0);
        if (!cont || any_edge) begin
            idle_cnt = '0;
        end else if (idle_reg != {TickW{1'b1}}) begin
            idle_cnt = idle_reg + 1'b1;
        end else begin
            idle_cnt = idle_reg;
        end

        diff_one = {1'b0, tick.current_one_code} - {1'b0, cfg.current_zero_code};
        diff_two = {1'b0, tick.current_two_code} - {1'b0, cfg.current_zero_code};
        abs_one  = diff_one[CodeW] ? -diff_one : diff_one;
        abs_two  = diff_two[CodeW] ? -diff_two : diff_two;
        over_one = abs_one > {1'b0, cfg.current_limit_code};
        over_two = abs_two > {1'b0, cfg.current_limit_code};
        stall    = cont && (idle_cnt > cfg.stall_timeout_ticks);

        fault_next  = fault_held;
        lcause_next = lcause_held;
        if ((over_one || over_two) && !fault_held) begin
            fault_next  = 1'b1;
            lcause_next = CAUSE_OVERCURRENT;
        end else if (!(over_one || over_two) && stall && !fault_held) begin
            fault_next  = 1'b1;
            lcause_next = CAUSE_STALL;
        end

        dir   = req;
        cause = CAUSE_NONE;
        if (fault_next) begin
            dir   = DIR_STOP;
            cause = lcause_next;
        end else if (req == DIR_UP && h_fin >= cfg.upper_limit_pulses) begin
            dir   = DIR_STOP;
            cause = CAUSE_UPPER_LIMIT;
        end else if (req == DIR_DOWN && h_fin <= cfg.lower_limit_pulses) begin
            dir   = DIR_STOP;
            cause = CAUSE_LOWER_LIMIT;
        end

        idle_next = (dir == DIR_STOP) ? '0 : idle_cnt;
        mode_next = dir;

        result.drive_direction = dir;
        result.duty_out        = (dir != DIR_STOP) ? cfg.drive_duty : '0;
        result.height_pulses   = h_fin;
        result.stop_cause      = cause;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_one_reg <= '0;
            pos_two_reg <= '0;
            idle_reg    <= '0;
            mode_reg    <= DIR_STOP;
            fault_reg   <= 1'b0;
            lcause_reg  <= CAUSE_NONE;
        end else if (step_en) begin
            pos_one_reg <= pos_one_next;
            pos_two_reg <= pos_two_next;
            idle_reg    <= idle_next;
            mode_reg    <= mode_next;
            fault_reg   <= fault_next;
            lcause_reg  <= lcause_next;
        end
    end

endmodule
`default_nettype wire

### rtl/core/dual_motor_lift_guard_top.sv
// A word accepted on s_ goes through the input register and then the result register to m_.
// One word per cycle while m_tready is high; each tick is evaluated in a single pass between them.
// Reset (aresetn low at a clock edge, synchronous) empties both registers, zeroes positions
// and the idle counter, stops motion, clears the fault latch, and loads the register defaults.
`default_nettype none
module dual_motor_lift_guard_top
    import dmlg_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // press_up, press_down, edges_motor_one, edges_motor_two, current_one_code,
    // current_two_code, upper bits unused
    input  wire logic [DataW-1:0]     s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // drive_direction, duty_out, height_pulses, stop_cause, zero fill
    output logic [DataW-1:0]          m_tdata,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CfgIndexW-1:0] cfg_index,
    input  wire logic [CfgDataW-1:0]  cfg_wdata
);

    localparam int unsigned TickBits = $bits(tick_t);
    localparam int unsigned ResBits  = $bits(result_t);

    cfg_t    cfg;
    tick_t   tick_reg;
    logic    in_valid_reg;
    result_t res_comb;
    result_t res_reg;
    logic    out_valid_reg;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    dmlg_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dmlg_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .tick    (tick_reg),
        .cfg     (cfg),
        .result  (res_comb)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            tick_reg <= s_tdata[TickBits-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            res_reg <= res_comb;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(DataW-ResBits){1'b0}}, res_reg};

endmodule
`default_nettype wire
